// ===== sv/ias_pkg.sv =====
// ----------------------------------------------------------------------------
// ias_pkg: shared types and constants for the indel pattern search
// Widths, the chain depth, the link and broadcast structs, the controller
// states and the saturating distance helpers.
// ----------------------------------------------------------------------------
package ias_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int POS_W       = 32;
  localparam int SYM_W       = 8;
  localparam int DIST_W      = 7;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int DIST_CAP    = (1 << DIST_W) - 1;

  typedef logic [SYM_W-1:0]  sym_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [POS_W-1:0]  pos_t;

  // Request operation codes
  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_SCAN   = 1'b1
  } op_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_HOLD
  } state_t;

  // Data handed from one cell to the next
  typedef struct packed {
    logic  tok;   // wavefront marker
    dist_t up;    // new value of the cell above
    dist_t diag;  // old value of the cell above
  } link_t;

  // Signals seen by every cell
  typedef struct packed {
    logic restart;
    sym_t load_sym;
    sym_t text_sym;
  } bcast_t;

  // Add one, holding at the cap
  function automatic dist_t inc_cap(input dist_t v);
    dist_t res;
    if (v == dist_t'(DIST_CAP)) begin
      res = v;
    end else begin
      res = v + dist_t'(1);
    end
    return res;
  endfunction

  // Column reset value of cell i: i + 1, capped
  function automatic dist_t init_dist(input int i);
    dist_t res;
    if (i + 1 > DIST_CAP) begin
      res = dist_t'(DIST_CAP);
    end else begin
      res = dist_t'(i + 1);
    end
    return res;
  endfunction

endpackage

// ===== sv/ias_cell.sv =====
// ----------------------------------------------------------------------------
// ias_cell: one pattern position of the search chain
// Holds one pattern symbol and one column entry. When the wavefront passes,
// it updates the entry from the values handed on by the cell above and
// hands its own new and old values to the cell below.
// ----------------------------------------------------------------------------
module ias_cell import ias_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  bcast_t bc,
  input  logic   sel,
  input  logic   active,
  input  dist_t  init_val,
  input  link_t  lnk_in,
  output link_t  lnk_out
);

  sym_t  pat_r;
  dist_t dist_r;
  logic  tok_r;
  dist_t up_r;
  dist_t diag_r;
  dist_t nv;
  dist_t from_up;
  dist_t from_left;

  // Column update: copy the diagonal on a hit, else cheapest indel
  always_comb begin
    from_up   = inc_cap(lnk_in.up);
    from_left = inc_cap(dist_r);
    if (pat_r == bc.text_sym) begin
      nv = lnk_in.diag;
    end else if (from_up < from_left) begin
      nv = from_up;
    end else begin
      nv = from_left;
    end
  end

  // Store the pattern symbol when addressed
  always_ff @(posedge clk) begin
    if (sel) begin
      pat_r <= bc.load_sym;
    end
  end

  // Hold the column entry; restart or update it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= init_val;
      tok_r  <= 1'b0;
    end else begin
      tok_r <= lnk_in.tok;
      if (bc.restart) begin
        dist_r <= init_val;
      end else if (lnk_in.tok && active) begin
        dist_r <= nv;
      end
    end
  end

  // Pass values on; inactive cells forward the value from above
  always_ff @(posedge clk) begin
    up_r   <= active ? nv : lnk_in.up;
    diag_r <= dist_r;
  end

  assign lnk_out = '{tok: tok_r, up: up_r, diag: diag_r};

endmodule

// ===== sv/indel_approximate_pattern_search.sv =====
// ----------------------------------------------------------------------------
// indel_approximate_pattern_search: indel-only approximate pattern search
// Loads a byte pattern, then scans text bytes and reports per text byte the
// insertion/deletion distance of the whole pattern ending there.
// ----------------------------------------------------------------------------
// The pattern (up to MAX_PATTERN bytes) sits in a chain of cells, one per
// pattern position, each holding its symbol and its column entry. A pattern
// append yields no result; it also restarts the column and the text
// position. A text request sends a wavefront down the whole chain, one cell
// per cycle, through all MAX_PATTERN cells whatever the pattern length. The
// result then waits for as long as a stalled earlier result still occupies
// the output register; the next request is taken once the result has moved
// to the output register. match_found is set when the distance is at most
// max_edits. end_position counts text bytes from 0 and saturates.
module indel_approximate_pattern_search import ias_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [7:0]  in_symbol,
  input  logic        in_first,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_match_found,
  output logic [31:0] out_end_position,
  output logic [6:0]  out_distance,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_max_edits
);

  state_t state_r, state_nxt;
  len_t   len_r;
  sym_t   sym_r;
  logic   tok0_r;
  pos_t   pos_r;
  pos_t   item_pos_r;
  dist_t  pend_r;
  dist_t  max_edits_r;
  logic   out_valid_r;
  logic   out_match_r;
  pos_t   out_pos_r;
  dist_t  out_dist_r;

  logic   acc;
  logic   acc_append;
  logic   acc_scan;
  logic   do_load;
  logic   wr_ok;
  idx_t   wr_idx;
  logic   out_free;
  logic   sweep_done;
  pos_t   base_pos;
  bcast_t bc;

  link_t  links [MAX_PATTERN+1];
  logic   sel   [MAX_PATTERN];
  logic   act   [MAX_PATTERN];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (acc_scan)   state_nxt = ST_SWEEP;
      ST_SWEEP: if (sweep_done) state_nxt = ST_HOLD;
      ST_HOLD:  if (out_free)   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_stall   = 1'b1;
    do_load    = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_stall = 1'b0;
      ST_SWEEP: in_stall = 1'b1;
      ST_HOLD:  do_load  = out_free;
      default:  in_stall = 1'b1;
    endcase
  end

  assign acc        = in_valid && !in_stall;
  assign acc_append = acc && (in_operation == OP_APPEND);
  assign acc_scan   = acc && (in_operation == OP_SCAN);
  assign out_free   = !out_valid_r || !out_stall;
  assign sweep_done = links[MAX_PATTERN].tok;

  // Pattern write slot: cleared pattern starts at zero, full pattern drops
  assign wr_idx = in_first ? idx_t'(0) : len_r[IDX_W-1:0];
  assign wr_ok  = in_first || (len_r < len_t'(MAX_PATTERN));
  assign base_pos = in_first ? pos_t'(0) : pos_r;

  assign bc = '{restart:  acc_append || (acc_scan && in_first),
                load_sym: in_symbol,
                text_sym: sym_r};

  assign links[0] = '{tok: tok0_r, up: dist_t'(0), diag: dist_t'(0)};

  // Chain of cells, one per pattern position
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    assign sel[i] = acc_append && wr_ok && (wr_idx == idx_t'(i));
    assign act[i] = len_r > len_t'(i);
    ias_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .bc       (bc),
      .sel      (sel[i]),
      .active   (act[i]),
      .init_val (init_dist(i)),
      .lnk_in   (links[i]),
      .lnk_out  (links[i+1])
    );
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      tok0_r      <= 1'b0;
      pos_r       <= '0;
      max_edits_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tok0_r  <= acc_scan;
      if (cfg_valid && cfg_ready) begin
        max_edits_r <= cfg_max_edits;
      end
      // Append: grow or restart the pattern, restart the position
      if (acc_append) begin
        pos_r <= '0;
        if (in_first) begin
          len_r <= len_t'(1);
        end else if (wr_ok) begin
          len_r <= len_r + len_t'(1);
        end
      end
      // Scan: advance the position, holding at the top
      if (acc_scan) begin
        pos_r <= (base_pos == '1) ? base_pos : base_pos + pos_t'(1);
      end
      if (do_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (acc_scan) begin
      sym_r      <= in_symbol;
      item_pos_r <= base_pos;
    end
    if (sweep_done) begin
      pend_r <= links[MAX_PATTERN].up;
    end
    if (do_load) begin
      out_match_r <= pend_r <= max_edits_r;
      out_pos_r   <= item_pos_r;
      out_dist_r  <= pend_r;
    end
  end

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_match_found  = out_match_r;
  assign out_end_position = out_pos_r;
  assign out_distance     = out_dist_r;

endmodule

// ===== sim/tb_indel_approximate_pattern_search.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indel_approximate_pattern_search: self-checking bench for the indel search
// Loads byte patterns and scans text through the request channel. A
// behavioural column model predicts each distance but those of typed
// directed rows. Every result is compared field by field under random
// idling, a long receiver hold-off and several max_edits settings.
// ----------------------------------------------------------------------------
module tb_indel_approximate_pattern_search;
  import ias_pkg::*;

  localparam int SETTLE_CYCLES = MAX_PATTERN + 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 650;
  localparam int QUIET_FROM    = 560;
  localparam int END_LIMIT     = 20000;
  localparam int N_DIRECTED    = 17;
  localparam int HOLD_PHASE    = 4;

  typedef struct packed {
    logic  match;
    pos_t  pos;
    dist_t distance;
  } search_result_t;

  typedef struct packed {
    op_t            op;
    sym_t           sym;
    logic           first;
    logic           typed;
    search_result_t res;
  } directed_row_t;

  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_stall;
  logic        in_operation     = 1'b0;
  logic [7:0]  in_symbol        = 8'h00;
  logic        in_first         = 1'b0;
  logic        out_valid;
  logic        out_stall        = 1'b0;
  logic        out_match_found;
  logic [31:0] out_end_position;
  logic [6:0]  out_distance;
  logic        cfg_valid        = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_max_edits    = 7'd0;

  // Behavioural copy of the search state
  sym_t  pat_sym  [MAX_PATTERN];
  int    pat_len;
  dist_t dist_col [MAX_PATTERN];
  pos_t  text_pos;
  dist_t edit_limit;

  search_result_t pending_results[$];

  int fail_count  = 0;
  int n_requests  = 0;
  int n_results   = 0;
  int n_matches   = 0;
  int n_settings  = 0;
  int n_phases    = 0;
  bit quiet       = 1'b0;
  bit hold_req    = 1'b0;

  // Directed requests; typed rows carry their result, the rest use the model
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{OP_SCAN,   8'h00, 1'b0, 1'b1, '{1'b1, 32'd0, 7'd0}},
    '{OP_SCAN,   8'hFF, 1'b0, 1'b1, '{1'b1, 32'd1, 7'd0}},
    '{OP_SCAN,   8'hAA, 1'b1, 1'b1, '{1'b1, 32'd0, 7'd0}},
    '{OP_APPEND, 8'h00, 1'b1, 1'b0, '{1'b0, 32'd0, 7'd0}},
    '{OP_APPEND, 8'hFF, 1'b0, 1'b0, '{1'b0, 32'd0, 7'd0}},
    '{OP_APPEND, 8'h5A, 1'b0, 1'b0, '{1'b0, 32'd0, 7'd0}},
    '{OP_SCAN,   8'h00, 1'b0, 1'b1, '{1'b0, 32'd0, 7'd2}},
    '{OP_SCAN,   8'hFF, 1'b0, 1'b0, '{1'b0, 32'd0, 7'd0}},
    '{OP_SCAN,   8'h5A, 1'b0, 1'b1, '{1'b1, 32'd2, 7'd0}},
    '{OP_SCAN,   8'h00, 1'b1, 1'b1, '{1'b0, 32'd0, 7'd2}},
    '{OP_SCAN,   8'h5A, 1'b0, 1'b0, '{1'b0, 32'd0, 7'd0}},
    '{OP_APPEND, 8'h11, 1'b0, 1'b0, '{1'b0, 32'd0, 7'd0}},
    '{OP_SCAN,   8'h11, 1'b0, 1'b1, '{1'b0, 32'd0, 7'd3}},
    '{OP_APPEND, 8'h80, 1'b1, 1'b0, '{1'b0, 32'd0, 7'd0}},
    '{OP_SCAN,   8'h7F, 1'b0, 1'b1, '{1'b0, 32'd0, 7'd1}},
    '{OP_SCAN,   8'h80, 1'b0, 1'b1, '{1'b1, 32'd1, 7'd0}},
    '{OP_SCAN,   8'h01, 1'b0, 1'b0, '{1'b0, 32'd0, 7'd0}}
  };

  indel_approximate_pattern_search dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_symbol        (in_symbol),
    .in_first         (in_first),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_match_found  (out_match_found),
    .out_end_position (out_end_position),
    .out_distance     (out_distance),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_max_edits    (cfg_max_edits)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("Timeout: run did not complete within the time limit");
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic dist_t inc_sat(input dist_t v);
    return (v == '1) ? v : dist_t'(v + 1'b1);
  endfunction

  // Restore the column to 1..m and restart the text count
  function automatic void restart_text();
    for (int i = 0; i < MAX_PATTERN; i++) begin
      dist_col[i] = dist_t'((i + 1 > DIST_CAP) ? DIST_CAP : i + 1);
    end
    text_pos = '0;
  endfunction

  // Apply one request to the model; return 1 when it yields a result
  function automatic bit advance_search(input op_t op, input sym_t s, input logic first,
                                        output search_result_t r);
    dist_t diag;
    dist_t up;
    dist_t prev;
    dist_t nv;
    r = '0;
    if (op == OP_APPEND) begin
      if (first) begin
        pat_len = 0;
      end
      if (pat_len < MAX_PATTERN) begin
        pat_sym[pat_len] = s;
        pat_len++;
      end
      restart_text();
      return 1'b0;
    end
    if (first) begin
      restart_text();
    end
    diag = '0;
    up   = '0;
    for (int i = 0; i < pat_len; i++) begin
      prev = dist_col[i];
      if (pat_sym[i] == s) begin
        nv = diag;
      end else begin
        nv = (inc_sat(up) < inc_sat(prev)) ? inc_sat(up) : inc_sat(prev);
      end
      dist_col[i] = nv;
      diag        = prev;
      up          = nv;
    end
    r.match    = (up <= edit_limit);
    r.pos      = text_pos;
    r.distance = up;
    if (text_pos != '1) begin
      text_pos = text_pos + 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic void note_failure(input string what);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] %s", $time, what);
    end
  endfunction

  function automatic sym_t pick_symbol(input sym_t alpha [4], input int n);
    if (n == 0) begin
      return sym_t'($urandom_range(0, 255));
    end
    return alpha[$urandom_range(0, n - 1)];
  endfunction

  // Offer one request, hold it until taken, then queue its expected result
  task automatic send_request(input op_t op, input sym_t s, input logic first,
                              input logic typed, input search_result_t typed_res);
    search_result_t r;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_symbol    <= s;
    in_first     <= first;
    do @(posedge clk); while (!(in_valid && !in_stall));
    if (advance_search(op, s, first, r)) begin
      pending_results.push_back(typed ? typed_res : r);
    end
    n_requests++;
  endtask

  // Stop offering and wait for every outstanding result, plus scan latency
  task automatic drain_requests();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_edits(input dist_t v);
    cfg_valid     <= 1'b1;
    cfg_max_edits <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid  <= 1'b0;
    edit_limit = v;
    n_settings++;
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    search_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (out_match_found) begin
        n_matches++;
      end
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result: match=%0b pos=%0d dist=%0d",
                               out_match_found, out_end_position, out_distance));
      end else begin
        want = pending_results.pop_front();
        if (out_match_found !== want.match || out_end_position !== want.pos ||
            out_distance !== want.distance) begin
          note_failure($sformatf(
            "mismatch: expected match=%0b pos=%0d dist=%0d, got match=%0b pos=%0d dist=%0d",
            want.match, want.pos, want.distance,
            out_match_found, out_end_position, out_distance));
        end
      end
    end
  end

  initial begin
    int             n_random;
    int             plen;
    int             k;
    int             n_text;
    int             alpha_n;
    int             phase;
    int             waited;
    sym_t           alphabet [4];
    sym_t           pat_copy [$];
    sym_t           s;
    logic           f;
    dist_t          lim;
    search_result_t no_res;

    no_res     = '0;
    pat_len    = 0;
    edit_limit = '0;
    restart_text();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset value of max_edits
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].sym, directed_rows[i].first,
                   directed_rows[i].typed, directed_rows[i].res);
    end

    // Random phases: new setting, new pattern, then a text built around it
    phase    = 0;
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      drain_requests();
      case (phase)
        0: lim = 7'd127;
        1: lim = 7'd64;
        2: lim = 7'd0;
        default: begin
          case ($urandom_range(0, 4))
            0: lim = 7'd0;
            1: lim = 7'd64;
            2: lim = 7'd127;
            3: lim = dist_t'($urandom_range(0, 8));
            default: lim = dist_t'($urandom_range(0, 127));
          endcase
        end
      endcase
      write_max_edits(lim);

      // Small alphabets give frequent hits; zero means the full byte range
      alpha_n = $urandom_range(0, 4);
      for (int j = 0; j < 4; j++) begin
        alphabet[j] = sym_t'($urandom_range(0, 255));
      end

      if (phase == 3 || $urandom_range(0, 11) == 0) begin
        plen = MAX_PATTERN;
      end else if ($urandom_range(0, 3) == 0) begin
        plen = $urandom_range(9, 24);
      end else begin
        plen = $urandom_range(1, 8);
      end

      // Load the pattern, usually clearing the old one first
      pat_copy.delete();
      for (int j = 0; j < plen; j++) begin
        s = pick_symbol(alphabet, alpha_n);
        f = (j == 0) ? (plen == MAX_PATTERN || $urandom_range(0, 7) != 0) : 1'b0;
        send_request(OP_APPEND, s, f, 1'b0, no_res);
        pat_copy.push_back(s);
        n_random++;
      end
      // Overfill a full pattern; these appends are dropped by the block
      if (plen == MAX_PATTERN) begin
        repeat ($urandom_range(1, 3)) begin
          send_request(OP_APPEND, pick_symbol(alphabet, alpha_n), 1'b0, 1'b0, no_res);
        end
      end

      if (phase == HOLD_PHASE) begin
        hold_req = 1'b1;
      end
      n_text = (phase == HOLD_PHASE) ? 24 : $urandom_range(4, 30);
      k = 0;
      for (int j = 0; j < n_text; j++) begin
        // Mostly follow the pattern, with skips and inserted symbols
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            s = pat_copy[k];
            k = (k + 1) % plen;
          end
          6: begin
            k = (k + 1) % plen;
            s = pat_copy[k];
            k = (k + 1) % plen;
          end
          7: s = pick_symbol(alphabet, alpha_n);
          8: s = sym_t'($urandom_range(0, 255));
          default: s = pat_copy[k];
        endcase
        f = (j == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 19) == 0);
        // Now and then change the pattern in the middle of a text
        if ($urandom_range(0, 29) == 0) begin
          send_request(OP_APPEND, sym_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                       1'b0, no_res);
          n_random++;
        end
        send_request(OP_SCAN, s, f, 1'b0, no_res);
        n_random++;
        quiet = (n_random >= QUIET_FROM);
      end
      phase++;
    end
    n_phases = phase;

    // Wait for the tail of the run, bounded
    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < END_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      note_failure($sformatf("%0d expected results never arrived", pending_results.size()));
    end

    $display("Covered %0d requests in %0d random phases over %0d max_edits settings,",
             n_requests, n_phases, n_settings);
    $display("checking %0d results of which %0d were matches; %0d failures.",
             n_results, n_matches, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
